@@ sv/frame_rate_scheduler_timebase_defines.svh @@
// Assertion macros shared by the scheduler timebase RTL.
`ifndef FRAME_RATE_SCHEDULER_TIMEBASE_DEFINES_SVH
`define FRAME_RATE_SCHEDULER_TIMEBASE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame scheduler check failed");

// Next-cycle implication, disabled during reset.
`define FRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame scheduler check failed");

`endif

@@ sv/frs_pkg.sv @@
`default_nettype none

package frs_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_CYCLES_PER_US = 3'd0;
    localparam logic [2:0] REG_FRAME_LENGTH  = 3'd1;
    localparam logic [2:0] REG_DIV_500HZ     = 3'd2;
    localparam logic [2:0] REG_DIV_100HZ     = 3'd3;
    localparam logic [2:0] REG_DIV_50HZ      = 3'd4;
    localparam logic [2:0] REG_DIV_10HZ      = 3'd5;
    localparam logic [2:0] REG_DIV_5HZ       = 3'd6;
    localparam logic [2:0] REG_DIV_1HZ       = 3'd7;

    localparam int unsigned NUM_RATES = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values
    localparam logic [7:0]  RST_CYCLES_PER_US = 8'd72;
    localparam logic [15:0] RST_FRAME_LENGTH  = 16'd1000;
    localparam logic [15:0] RST_DIV [NUM_RATES] = '{
        16'd2, 16'd10, 16'd20, 16'd100, 16'd200, 16'd1000
    };

    localparam logic [31:0] US_PER_MS = 32'd1000;

    // Barometer phase codes
    localparam logic [1:0] BARO_NONE = 2'd0;
    localparam logic [1:0] BARO_TEMP = 2'd1;
    localparam logic [1:0] BARO_PRES = 2'd2;

    // Shared divider geometry
    localparam int unsigned DIV_DIVIDEND_W = 32;
    localparam int unsigned DIV_DIVISOR_W  = 16;
    localparam int unsigned DIV_STEP_W     = 6;

    typedef struct packed {
        logic        cmd;
        logic [31:0] cycle_count;
        logic        system_ready;
        logic        console_busy;
        logic        accel_calibrating;
        logic        esc_calibrating;
        logic        mag_calibrating;
        logic        gyro_calibrating;
        logic        temp_pending;
    } t_in;

    typedef struct packed {
        logic [15:0] frame_number;
        logic [5:0]  rate_strobes;
        logic        mag_read;
        logic [1:0]  baro_action;
        logic [31:0] time_us;
        logic [31:0] delta_us;
        logic [31:0] uptime_ms;
    } t_out;

    typedef struct packed {
        logic                      start;
        logic [DIV_DIVIDEND_W-1:0] dividend;
        logic [DIV_DIVISOR_W-1:0]  divisor;
        logic [DIV_STEP_W-1:0]     steps;
    } t_div_req;

    typedef struct packed {
        logic                      busy;
        logic                      done;
        logic                      div_zero;
        logic [DIV_DIVIDEND_W-1:0] quotient;
        logic [DIV_DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ sv/frs_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is consumed
// MSB first for the given number of steps; a short run leaves the remainder
// of the top bits only.
module frs_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire frs_pkg::t_div_req i_req,
    output frs_pkg::t_div_rsp      o_rsp
);

    logic [frs_pkg::DIV_DIVIDEND_W-1:0] r_q;
    logic [frs_pkg::DIV_DIVISOR_W-1:0]  r_rem;
    logic [frs_pkg::DIV_DIVISOR_W-1:0]  r_div;
    logic [frs_pkg::DIV_STEP_W-1:0]     r_cnt;
    logic                               r_busy;
    logic                               r_done;

    logic [frs_pkg::DIV_DIVISOR_W:0]    w_rem_sh;
    logic                               w_ge;
    logic [frs_pkg::DIV_DIVISOR_W:0]    w_rem_sub;

    always_comb begin
        w_rem_sh  = {r_rem, r_q[frs_pkg::DIV_DIVIDEND_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_div});
        w_rem_sub = w_rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == frs_pkg::DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[frs_pkg::DIV_DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[frs_pkg::DIV_DIVISOR_W-1:0]
                          : w_rem_sh[frs_pkg::DIV_DIVISOR_W-1:0];
        end
    end

    always_comb begin
        o_rsp.busy      = r_busy;
        o_rsp.done      = r_done;
        o_rsp.div_zero  = (r_div == '0);
        o_rsp.quotient  = r_q;
        o_rsp.remainder = r_rem;
    end

endmodule

`default_nettype wire

@@ sv/frame_rate_scheduler_timebase.sv @@
//  channel   direction  handshake             payload
//  request   in         i_valid / o_ready     i_in  (frs_pkg::t_in)
//  result    out        o_valid / i_ready     o_out (frs_pkg::t_out)
//  config    in         i_cfg_we, no wait     i_cfg_idx, i_cfg_data
//
//  Query: one 32-step pass of the shared divider.
//  Frame tick: a time pass then seven 17-step remainder passes (six rate
//  divisors, one lookahead). Other tick: no divider pass.
//  Reset is synchronous, active low: load the register defaults and clear
//  uptime, cycle stamp, frame number and last frame time.
//  Hold a stalled result in the output register; take the next request meanwhile.
`include "frame_rate_scheduler_timebase_defines.svh"
`default_nettype none

module frame_rate_scheduler_timebase (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire frs_pkg::t_in                      i_in,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output frs_pkg::t_out                          o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [frs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [frs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TBASE = 3'd1;
    localparam logic [2:0] S_TIME  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // Remainder jobs 0..5 are the rate divisors; job 6 is the mag lookahead
    localparam logic [2:0] JOB_BARO = 3'd1;
    localparam logic [2:0] JOB_MAG  = 3'd6;
    localparam logic [2:0] DIV_10HZ_SLOT = 3'd3;

    localparam logic [frs_pkg::DIV_STEP_W-1:0] STEPS_TIME = frs_pkg::DIV_STEP_W'(32);
    localparam logic [frs_pkg::DIV_STEP_W-1:0] STEPS_MOD  = frs_pkg::DIV_STEP_W'(17);

    // Configuration registers
    logic [7:0]  r_cpu;
    logic [15:0] r_frame_len;
    logic [15:0] r_div [frs_pkg::NUM_RATES];

    // Timebase state
    logic [31:0] r_uptime;
    logic [31:0] r_stamp;
    logic [15:0] r_frame;
    logic [31:0] r_last;

    // Per-request working registers
    logic [2:0]  r_state, n_state;
    logic [2:0]  r_job;
    logic        r_cmd;
    logic        r_temp_pending;
    logic [31:0] r_base;
    logic [31:0] r_tus;
    logic [31:0] r_dus;
    logic [5:0]  r_strobes;
    logic        r_mag;
    logic [1:0]  r_baro;

    logic          r_o_valid;
    frs_pkg::t_out r_out;

    frs_pkg::t_div_req w_req;
    frs_pkg::t_div_rsp w_rsp;

    logic        w_accept;
    logic        w_frame_ok;
    logic [16:0] w_next17;
    logic [15:0] w_next_frame;
    logic [16:0] w_frame_p1;
    logic [2:0]  w_next_job;
    logic [2:0]  w_div_idx;
    logic        w_hit;
    logic [31:0] w_tus;
    logic        w_out_free;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    // Frame work only when ready, console idle and no calibration
    assign w_frame_ok = i_in.system_ready && !i_in.console_busy &&
                        !(i_in.accel_calibrating || i_in.esc_calibrating ||
                          i_in.mag_calibrating || i_in.gyro_calibrating);

    // Advance frame without loss; wrap to 1 above the frame length
    assign w_next17     = {1'b0, r_frame} + 17'd1;
    assign w_next_frame = (w_next17 > {1'b0, r_frame_len}) ? 16'd1 : w_next17[15:0];
    assign w_frame_p1   = {1'b0, r_frame} + 17'd1;

    assign w_tus = r_base + w_rsp.quotient;
    assign w_hit = !w_rsp.div_zero && (w_rsp.remainder == '0);

    // Next remainder job: first after the time pass, else the following one
    assign w_next_job = (r_state == S_TIME) ? 3'd0 : r_job + 3'd1;
    assign w_div_idx  = (w_next_job == JOB_MAG) ? DIV_10HZ_SLOT : w_next_job;

    // Drive the shared divider
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = '0;
        w_req.divisor  = '0;
        w_req.steps    = STEPS_TIME;
        unique case (r_state)
            S_IDLE: begin
                // Query: elapsed cycles over cycles per microsecond
                w_req.start    = w_accept && i_in.cmd;
                w_req.dividend = i_in.cycle_count - r_stamp;
                w_req.divisor  = {8'd0, r_cpu};
            end
            S_TBASE: begin
                // Stamp was just taken from the same sample: elapsed is zero
                w_req.start   = 1'b1;
                w_req.divisor = {8'd0, r_cpu};
            end
            S_TIME, S_MOD: begin
                w_req.start    = w_rsp.done && !(r_state == S_TIME && r_cmd) &&
                                 !(r_state == S_MOD && r_job == JOB_MAG);
                w_req.dividend = (w_next_job == JOB_MAG) ? {w_frame_p1, 15'd0}
                                                         : {1'b0, r_frame, 15'd0};
                w_req.divisor  = r_div[w_div_idx];
                w_req.steps    = STEPS_MOD;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    frs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.cmd) begin
                        n_state = S_TIME;
                    end else if (w_frame_ok) begin
                        n_state = S_TBASE;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_TBASE: begin
                n_state = S_TIME;
            end
            S_TIME: begin
                if (w_rsp.done) begin
                    n_state = r_cmd ? S_OUT : S_MOD;
                end
            end
            S_MOD: begin
                if (w_rsp.done && r_job == JOB_MAG) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and timebase state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_cpu       <= frs_pkg::RST_CYCLES_PER_US;
            r_frame_len <= frs_pkg::RST_FRAME_LENGTH;
            for (int i = 0; i < frs_pkg::NUM_RATES; i++) begin
                r_div[i] <= frs_pkg::RST_DIV[i];
            end
            r_uptime    <= '0;
            r_stamp     <= '0;
            r_frame     <= '0;
            r_last      <= '0;
        end else begin
            r_state <= n_state;

            // Config writes must arrive only while idle; the block does not enforce it
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    frs_pkg::REG_CYCLES_PER_US: r_cpu <= i_cfg_data[7:0];
                    frs_pkg::REG_FRAME_LENGTH:  r_frame_len <= i_cfg_data;
                    frs_pkg::REG_DIV_500HZ, frs_pkg::REG_DIV_100HZ,
                    frs_pkg::REG_DIV_50HZ, frs_pkg::REG_DIV_10HZ,
                    frs_pkg::REG_DIV_5HZ, frs_pkg::REG_DIV_1HZ: begin
                        r_div[3'(i_cfg_idx - frs_pkg::REG_DIV_500HZ)] <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            // Tick: advance uptime, capture stamp, maybe advance frame
            if (w_accept && !i_in.cmd) begin
                r_uptime <= r_uptime + 32'd1;
                r_stamp  <= i_in.cycle_count;
                if (w_frame_ok) begin
                    r_frame <= w_next_frame;
                end
            end

            if (r_state == S_TIME && w_rsp.done && !r_cmd) begin
                r_last <= w_tus;
            end

            // Hold the result until taken
            if (r_state == S_OUT && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd          <= i_in.cmd;
            r_temp_pending <= i_in.temp_pending;
            r_base         <= r_uptime * frs_pkg::US_PER_MS;
            r_tus          <= '0;
            r_dus          <= '0;
            r_strobes      <= '0;
            r_mag          <= 1'b0;
            r_baro         <= frs_pkg::BARO_NONE;
        end

        if (r_state == S_TBASE) begin
            r_base <= r_uptime * frs_pkg::US_PER_MS;
        end

        if (r_state == S_TIME && w_rsp.done) begin
            r_tus <= w_tus;
            if (!r_cmd) begin
                r_dus <= w_tus - r_last;
            end
            r_job <= w_next_job;
        end

        if (r_state == S_MOD && w_rsp.done) begin
            r_job <= w_next_job;
            if (r_job == JOB_MAG) begin
                r_mag <= w_hit;
            end else begin
                r_strobes[r_job] <= w_hit;
                if (r_job == JOB_BARO && w_hit) begin
                    r_baro <= r_temp_pending ? frs_pkg::BARO_PRES : frs_pkg::BARO_TEMP;
                end
            end
        end

        if (r_state == S_OUT && w_out_free) begin
            r_out.frame_number <= r_frame;
            r_out.rate_strobes <= r_strobes;
            r_out.mag_read     <= r_mag;
            r_out.baro_action  <= r_baro;
            r_out.time_us      <= r_tus;
            r_out.delta_us     <= r_dus;
            r_out.uptime_ms    <= r_uptime;
        end
    end

    assign o_valid = r_o_valid;
    assign o_out   = r_out;

    // Divider is free whenever a request can be taken
    `FRS_ASSERT_NOW(a_idle_div_free, i_clk, i_rst_n, r_state == S_IDLE, !w_rsp.busy)
    // Never restart the divider in the middle of a pass
    `FRS_ASSERT_NOW(a_no_restart, i_clk, i_rst_n, w_req.start, !w_rsp.busy)
    // Divider completes only while the sequencer waits on it
    `FRS_ASSERT_NOW(a_done_expected, i_clk, i_rst_n, w_rsp.done,
        r_state == S_TIME || r_state == S_MOD)
    // An accepted request leaves idle
    `FRS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != S_IDLE)

endmodule

`default_nettype wire

@@ tb/tb_frame_rate_scheduler_timebase.sv @@
`default_nettype none

module tb_frame_rate_scheduler_timebase;
    import frs_pkg::*;

    localparam int SETTLE_CYCLES = 200;      // covers the longest frame tick
    localparam int HOLD_CYCLES   = 1500;     // long result stall for back-pressure
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int NUM_PHASES      = 8;

    // Bit positions of the rate strobes that carry side actions
    localparam int RATE_100HZ = 1;
    localparam int RATE_10HZ  = 3;

    // One full register image: cycles per microsecond, frame length, six divisors
    // ordered 500 Hz, 100 Hz, 50 Hz, 10 Hz, 5 Hz, 1 Hz.
    typedef struct packed {
        logic [7:0]        cpu;
        logic [15:0]       frame_len;
        logic [0:5][15:0]  divs;
    } reg_set_t;

    localparam reg_set_t SET_DEFAULT = '{8'd72, 16'd1000,
        {16'd2, 16'd10, 16'd20, 16'd100, 16'd200, 16'd1000}};
    localparam reg_set_t SET_SMALL = '{8'd1, 16'd4,
        {16'd1, 16'd2, 16'd4, 16'd2, 16'd3, 16'd4}};
    localparam reg_set_t SET_UNIT = '{8'd255, 16'd1,
        {16'd1, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1}};
    localparam reg_set_t SET_MAX = '{8'd255, 16'd65535,
        {16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535}};
    localparam reg_set_t SET_ZERO = '0;
    localparam reg_set_t KEEP = '0;
    localparam t_out NO_CHECK = '0;

    // Directed step: optional register reload before the request, and a typed
    // result where it is obvious by inspection.
    typedef struct {
        bit       reload;
        reg_set_t regs;
        t_in      req;
        bit       known;
        t_out     want;
    } step_row_t;

    // Request bits after cmd and cycle_count, in order:
    // ready, busy, accel, esc, mag, gyro, temp_pending.
    localparam int NUM_STEPS = 23;
    step_row_t directed_steps [NUM_STEPS] = '{
        // query straight out of reset: everything zero
        '{1'b0, KEEP, {1'b1, 32'h0, 7'b0000000}, 1'b1,
          '{16'd0, 6'd0, 1'b0, BARO_NONE, 32'd0, 32'd0, 32'd0}},
        // query with the largest cycle sample: 0xFFFFFFFF / 72
        '{1'b0, KEEP, {1'b1, 32'hFFFF_FFFF, 7'b0000000}, 1'b1,
          '{16'd0, 6'd0, 1'b0, BARO_NONE, 32'd59652323, 32'd0, 32'd0}},
        // ticks that are blocked from frame work: not ready, busy, each calibration
        '{1'b0, KEEP, {1'b0, 32'd100, 7'b0000000}, 1'b1,
          '{16'd0, 6'd0, 1'b0, BARO_NONE, 32'd0, 32'd0, 32'd1}},
        '{1'b0, KEEP, {1'b0, 32'd200, 7'b1100000}, 1'b1,
          '{16'd0, 6'd0, 1'b0, BARO_NONE, 32'd0, 32'd0, 32'd2}},
        '{1'b0, KEEP, {1'b0, 32'd300, 7'b1010000}, 1'b1,
          '{16'd0, 6'd0, 1'b0, BARO_NONE, 32'd0, 32'd0, 32'd3}},
        '{1'b0, KEEP, {1'b0, 32'd400, 7'b1001000}, 1'b1,
          '{16'd0, 6'd0, 1'b0, BARO_NONE, 32'd0, 32'd0, 32'd4}},
        '{1'b0, KEEP, {1'b0, 32'd500, 7'b1000100}, 1'b1,
          '{16'd0, 6'd0, 1'b0, BARO_NONE, 32'd0, 32'd0, 32'd5}},
        '{1'b0, KEEP, {1'b0, 32'd600, 7'b1000010}, 1'b1,
          '{16'd0, 6'd0, 1'b0, BARO_NONE, 32'd0, 32'd0, 32'd6}},
        // first frame: frame time is uptime * 1000
        '{1'b0, KEEP, {1'b0, 32'd1000, 7'b1000000}, 1'b1,
          '{16'd1, 6'd0, 1'b0, BARO_NONE, 32'd7000, 32'd7000, 32'd7}},
        // query 5 us plus a remainder after the tick
        '{1'b0, KEEP, {1'b1, 32'd1431, 7'b0000000}, 1'b1,
          '{16'd1, 6'd0, 1'b0, BARO_NONE, 32'd7005, 32'd0, 32'd7}},
        // frame two strobes 500 Hz
        '{1'b0, KEEP, {1'b0, 32'd5000, 7'b1000001}, 1'b1,
          '{16'd2, 6'd1, 1'b0, BARO_NONE, 32'd8000, 32'd1000, 32'd8}},
        // all fields at their top value, then a query with the sample wrapped
        '{1'b0, KEEP, {1'b0, 32'hFFFF_FFFF, 7'b1111111}, 1'b0, NO_CHECK},
        '{1'b0, KEEP, {1'b1, 32'h0, 7'b1111111}, 1'b0, NO_CHECK},
        // short frame cycle: every strobe, both barometer phases, lookahead, wrap
        '{1'b1, SET_SMALL, {1'b0, 32'd10, 7'b1000001}, 1'b0, NO_CHECK},
        '{1'b0, KEEP, {1'b0, 32'd20, 7'b1000000}, 1'b0, NO_CHECK},
        '{1'b0, KEEP, {1'b0, 32'd30, 7'b1000001}, 1'b0, NO_CHECK},
        '{1'b0, KEEP, {1'b0, 32'd40, 7'b1000001}, 1'b0, NO_CHECK},
        '{1'b0, KEEP, {1'b1, 32'h8000_0000, 7'b0000000}, 1'b0, NO_CHECK},
        // zero registers: frame pinned at one, no strobes, saturated quotient
        '{1'b1, SET_ZERO, {1'b0, 32'd50, 7'b1000000}, 1'b0, NO_CHECK},
        '{1'b0, KEEP, {1'b1, 32'd123, 7'b0000000}, 1'b0, NO_CHECK},
        // frame length of one
        '{1'b1, SET_UNIT, {1'b0, 32'd60, 7'b1000000}, 1'b0, NO_CHECK},
        // register maxima
        '{1'b1, SET_MAX, {1'b0, 32'd70, 7'b1000000}, 1'b0, NO_CHECK},
        '{1'b0, KEEP, {1'b1, 32'hFFFF_FFFF, 7'b0000000}, 1'b0, NO_CHECK}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in                   i_in;
    logic                  o_valid;
    logic                  i_ready;
    t_out                  o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frame_rate_scheduler_timebase dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Scheduler mirror: registers and timebase state as the block should hold them
    logic [7:0]  m_cpu;
    logic [15:0] m_frame_len;
    logic [15:0] m_rate_div [NUM_RATES];
    logic [31:0] m_uptime;
    logic [31:0] m_stamp;
    logic [15:0] m_frame;
    logic [31:0] m_last_frame_us;

    t_out sched_results_q [$];   // scheduler outputs still owed by the block
    int   mismatches = 0;
    int   cycle_count = 0;
    int   hold_left = 0;
    bit   hold_req = 1'b0;       // ask the result side for one long stall
    bit   steady = 1'b0;         // suppress idling on both sides

    // Microsecond time at a given cycle sample, modulo 2^32
    function automatic logic [31:0] us_now(input logic [31:0] cyc);
        logic [31:0] q;
        q = (m_cpu == 8'd0) ? 32'hFFFF_FFFF : (cyc - m_stamp) / {24'd0, m_cpu};
        return m_uptime * US_PER_MS + q;
    endfunction

    // A zero divisor never fires
    function automatic bit rate_hit(input logic [16:0] n, input logic [15:0] d);
        return (d != 16'd0) && ((n % {1'b0, d}) == 17'd0);
    endfunction

    function automatic void mirror_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [15:0] data);
        case (idx)
            REG_CYCLES_PER_US: m_cpu = data[7:0];
            REG_FRAME_LENGTH:  m_frame_len = data;
            default:           m_rate_div[idx - REG_DIV_500HZ] = data;
        endcase
    endfunction

    // Advance the mirror by one request and return the result it must produce
    function automatic t_out schedule_step(input t_in req);
        t_out        res;
        logic [16:0] nxt;
        res = '0;
        if (req.cmd) begin
            res.time_us = us_now(req.cycle_count);
        end else begin
            m_stamp = req.cycle_count;
            m_uptime = m_uptime + 32'd1;
            if (req.system_ready && !req.console_busy && !req.accel_calibrating &&
                !req.esc_calibrating && !req.mag_calibrating && !req.gyro_calibrating) begin
                // Increment in 17 bits so the frame never wraps to zero
                nxt = {1'b0, m_frame} + 17'd1;
                if (nxt > {1'b0, m_frame_len}) nxt = 17'd1;
                m_frame = nxt[15:0];
                res.time_us = us_now(req.cycle_count);
                res.delta_us = res.time_us - m_last_frame_us;
                m_last_frame_us = res.time_us;
                for (int k = 0; k < NUM_RATES; k++)
                    res.rate_strobes[k] = rate_hit({1'b0, m_frame}, m_rate_div[k]);
                if (res.rate_strobes[RATE_100HZ])
                    res.baro_action = req.temp_pending ? BARO_PRES : BARO_TEMP;
                // Magnetometer read one frame ahead of the 10 Hz strobe
                res.mag_read = rate_hit({1'b0, m_frame} + 17'd1, m_rate_div[RATE_10HZ]);
            end
        end
        res.frame_number = m_frame;
        res.uptime_ms = m_uptime;
        return res;
    endfunction

    // Write all eight registers on consecutive edges; block must be idle
    task automatic load_settings(input reg_set_t s);
        logic [15:0] vals [8];
        vals[0] = {8'd0, s.cpu};
        vals[1] = s.frame_len;
        for (int k = 0; k < NUM_RATES; k++) vals[2 + k] = s.divs[k];
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= REG_CYCLES_PER_US + 3'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            mirror_reg_write(REG_CYCLES_PER_US + 3'(k), vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every owed result, then let the block settle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sched_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offer one request, hold it until accepted, then record what it owes.
    // Valid stays high after acceptance so back-to-back requests need no gap.
    task automatic send_request(input t_in req, input bit known, input t_out want);
        t_out res;
        if (!steady && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= req;
        do @(posedge i_clk); while (!o_ready);
        res = schedule_step(req);
        sched_results_q.push_back(known ? want : res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: check each accepted result, then pick the next ready level
    always @(posedge i_clk) begin : result_side
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (sched_results_q.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                want = sched_results_q.pop_front();
                check_field("frame_number", 32'(want.frame_number), 32'(o_out.frame_number));
                check_field("rate_strobes", 32'(want.rate_strobes), 32'(o_out.rate_strobes));
                check_field("mag_read", 32'(want.mag_read), 32'(o_out.mag_read));
                check_field("baro_action", 32'(want.baro_action), 32'(o_out.baro_action));
                check_field("time_us", want.time_us, o_out.time_us);
                check_field("delta_us", want.delta_us, o_out.delta_us);
                check_field("uptime_ms", want.uptime_ms, o_out.uptime_ms);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_req) begin
            // Hold off long enough for the block to fill and stall requests
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= 7);
        end
    end

    // Hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        t_in      req;
        reg_set_t s;
        int       kind;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in <= '0;
        i_ready <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_CYCLES_PER_US;
        i_cfg_data <= '0;

        // Mirror starts from the reset image
        m_cpu = RST_CYCLES_PER_US;
        m_frame_len = RST_FRAME_LENGTH;
        m_rate_div = RST_DIV;
        m_uptime = '0;
        m_stamp = '0;
        m_frame = '0;
        m_last_frame_us = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: walk the table, reloading registers where a row asks
        for (int r = 0; r < NUM_STEPS; r++) begin
            if (directed_steps[r].reload) begin
                drain_results();
                load_settings(directed_steps[r].regs);
            end
            send_request(directed_steps[r].req, directed_steps[r].known,
                         directed_steps[r].want);
        end

        // Random part: one register image per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p)
                0: s = SET_SMALL;
                4: s = SET_ZERO;
                5: s = SET_MAX;
                7: s = SET_DEFAULT;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       s.cpu = 8'd1;
                        1:       s.cpu = 8'd255;
                        default: s.cpu = 8'($urandom_range(1, 255));
                    endcase
                    // Mostly short frame cycles so wraps and strobes come often
                    s.frame_len = ($urandom_range(0, 9) == 0) ?
                        16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 48));
                    for (int k = 0; k < NUM_RATES; k++)
                        s.divs[k] = ($urandom_range(0, 9) == 0) ?
                            16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 50));
                end
            endcase
            load_settings(s);
            hold_req = (p == 1);
            steady = (p == 2);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                req = '0;
                kind = $urandom_range(0, 99);
                // Mostly advance the cycle sample a little past the last tick
                req.cycle_count = ($urandom_range(0, 9) == 0) ?
                    $urandom() : m_stamp + $urandom_range(0, 200000);
                req.temp_pending = 1'($urandom_range(0, 1));
                if (kind < 60) begin
                    // well-formed frame tick
                    req.system_ready = 1'b1;
                end else if (kind < 80) begin
                    req.cmd = 1'b1;
                    {req.system_ready, req.console_busy, req.accel_calibrating,
                     req.esc_calibrating, req.mag_calibrating,
                     req.gyro_calibrating} = 6'($urandom());
                end else begin
                    // noise tick: gate bits random, frame work rarely allowed
                    {req.system_ready, req.console_busy, req.accel_calibrating,
                     req.esc_calibrating, req.mag_calibrating,
                     req.gyro_calibrating} = 6'($urandom());
                end
                send_request(req, 1'b0, NO_CHECK);
            end
            steady = 1'b0;
        end

        drain_results();
        if (sched_results_q.size() != 0) begin
            $error("%0d results never arrived", sched_results_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/frs_pkg.sv
sv/frs_div.sv
sv/frame_rate_scheduler_timebase.sv
tb/tb_frame_rate_scheduler_timebase.sv
